>>> src/lfu_pkg.sv
// Shared constants, types and cell command encoding for the LFU cache table.
// No dependencies; every other file of the block refers to it by scoped names.
package lfu_pkg;

  // Table geometry
  localparam int NumCells = 16;
  localparam int IdxW     = $clog2(NumCells);
  localparam int RankW    = IdxW;
  localparam int SettleW  = $clog2(NumCells + 1);

  // Field widths
  localparam int KeyW   = 32;
  localparam int DataW  = 32;
  localparam int CountW = 16;
  localparam int CapW   = 5;
  localparam int CntW   = (SettleW > CapW) ? SettleW : CapW;

  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};
  localparam logic [CapW-1:0]   CapReset = CapW'(NumCells);

  // Request operation codes
  localparam logic OpGet = 1'b0;
  localparam logic OpPut = 1'b1;

  typedef logic [IdxW-1:0]   idx_t;
  typedef logic [RankW-1:0]  rank_t;
  typedef logic [CountW-1:0] count_t;
  typedef logic [KeyW-1:0]   key_t;
  typedef logic [DataW-1:0]  data_t;

  // Update broadcast to every cell
  typedef enum logic [1:0] {
    CmdNone,
    CmdTouch,
    CmdInsert
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    logic     wr_data;   // touch also overwrites the stored value
    logic     do_evict;  // insert follows removal of a victim
    rank_t    rank_ref;  // rank of the touched cell or of the victim
    key_t     key;
    data_t    data;
  } cell_cmd_t;

  // Best eviction candidate seen so far along the chain
  typedef struct packed {
    logic   found;
    count_t count;
    rank_t  rank;
    idx_t   idx;
  } cand_t;

endpackage

>>> src/lfu_req_if.sv
// Request channel of the LFU cache table: valid/ready plus one request word.
// Depends on lfu_pkg for field widths.
interface lfu_req_if;
  logic                       valid;
  logic                       ready;
  logic                       operation;
  logic [lfu_pkg::KeyW-1:0]   key;
  logic [lfu_pkg::DataW-1:0]  value;

  modport source (output valid, output operation, output key, output value, input ready);
  modport sink   (input valid, input operation, input key, input value, output ready);
endinterface

>>> src/lfu_rsp_if.sv
// Response channel of the LFU cache table: valid/ready plus one result word.
// Depends on lfu_pkg for field widths.
interface lfu_rsp_if;
  logic                       valid;
  logic                       ready;
  logic                       hit;
  logic [lfu_pkg::DataW-1:0]  read_value;
  logic                       evicted;
  logic [lfu_pkg::KeyW-1:0]   evicted_key;

  modport source (output valid, output hit, output read_value, output evicted,
                  output evicted_key, input ready);
  modport sink   (input valid, input hit, input read_value, input evicted,
                  input evicted_key, output ready);
endinterface

>>> src/lfu_cell.sv
// One entry of the LFU table: key, value, use count, recency rank, and one
// stage of the victim search chain. Depends on lfu_pkg.
module lfu_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lfu_pkg::idx_t      cell_idx_i,
  input  lfu_pkg::cell_cmd_t cmd_i,
  input  logic               sel_i,
  input  logic               evict_i,
  input  lfu_pkg::key_t      req_key_i,
  input  lfu_pkg::cand_t     cand_i,
  output logic               valid_o,
  output logic               match_o,
  output lfu_pkg::key_t      key_o,
  output lfu_pkg::data_t     data_o,
  output lfu_pkg::rank_t     rank_o,
  output lfu_pkg::cand_t     cand_o
);

  logic            valid_q, valid_d;
  lfu_pkg::key_t   key_q, key_d;
  lfu_pkg::data_t  data_q, data_d;
  lfu_pkg::count_t count_q, count_d;
  lfu_pkg::rank_t  rank_q, rank_d;
  lfu_pkg::cand_t  cand_q, cand_d;
  logic            own_better;

  // Apply the broadcast update
  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    data_d  = data_q;
    count_d = count_q;
    rank_d  = rank_q;
    unique case (cmd_i.op)
      lfu_pkg::CmdTouch: begin
        if (sel_i) begin
          rank_d = '0;
          if (count_q != lfu_pkg::CountMax) begin
            count_d = count_q + 1'b1;
          end
          if (cmd_i.wr_data) begin
            data_d = cmd_i.data;
          end
        end else if (valid_q && (rank_q < cmd_i.rank_ref)) begin
          rank_d = rank_q + 1'b1;
        end
      end
      lfu_pkg::CmdInsert: begin
        if (sel_i) begin
          valid_d = 1'b1;
          key_d   = cmd_i.key;
          data_d  = cmd_i.data;
          count_d = lfu_pkg::CountW'(1);
          rank_d  = '0;
        end else if (evict_i) begin
          valid_d = 1'b0;
        end else if (valid_q) begin
          // entries behind the victim close the gap, then all age by one
          if (!(cmd_i.do_evict && (rank_q > cmd_i.rank_ref))) begin
            rank_d = rank_q + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // Keep the lower count, or the older entry on equal counts
  always_comb begin
    own_better = valid_q &&
                 (!cand_i.found || (count_q < cand_i.count) ||
                  ((count_q == cand_i.count) && (rank_q > cand_i.rank)));
    if (own_better) begin
      cand_d.found = 1'b1;
      cand_d.count = count_q;
      cand_d.rank  = rank_q;
      cand_d.idx   = cell_idx_i;
    end else begin
      cand_d = cand_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cand_q  <= '0;
    end else begin
      valid_q <= valid_d;
      cand_q  <= cand_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    data_q  <= data_d;
    count_q <= count_d;
    rank_q  <= rank_d;
  end

  assign valid_o = valid_q;
  assign match_o = valid_q && (key_q == req_key_i);
  assign key_o   = key_q;
  assign data_o  = data_q;
  assign rank_o  = rank_q;
  assign cand_o  = cand_q;

endmodule

>>> src/lfu_cache_table.sv
// LFU cache table: a 16-entry fully associative key/value store that evicts
// the least frequently used entry, oldest first on equal counts. Each request
// word is accepted in idle, then matched and committed in the match state
// when it is a get, a put that hits, or a put that finds room. A put to an
// absent key on a full table takes its victim from a chain of cells that
// passes the best candidate one cell per clock; such a put waits in the walk
// state until the chain has settled after the last table update. A result
// word waiting on the response channel holds the next request at its commit,
// and so holds off the input until the result word is taken.
// Depends on lfu_pkg, lfu_req_if, lfu_rsp_if and lfu_cell.
module lfu_cache_table (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  lfu_req_if.sink                    req_i,
  lfu_rsp_if.source                  rsp_o,
  input  logic                       cfg_we_i,
  input  logic [lfu_pkg::CapW-1:0]   cfg_data_i
);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StMatch = 2'd1;
  localparam logic [1:0] StWalk  = 2'd2;

  logic [1:0] state_q, state_d;

  logic [lfu_pkg::CapW-1:0]    cap_q;
  logic                        req_op_q;
  lfu_pkg::key_t               req_key_q;
  lfu_pkg::data_t              req_data_q;
  logic [lfu_pkg::SettleW-1:0] settle_q, settle_d;

  logic                 rsp_valid_q;
  logic                 rsp_hit_q, rsp_hit_d;
  lfu_pkg::data_t       rsp_value_q, rsp_value_d;
  logic                 rsp_evicted_q, rsp_evicted_d;
  lfu_pkg::key_t        rsp_evkey_q, rsp_evkey_d;

  logic [lfu_pkg::NumCells-1:0] valid_vec, match_vec, sel_vec, evict_vec, avail_vec;
  lfu_pkg::key_t                key_arr  [lfu_pkg::NumCells];
  lfu_pkg::data_t               data_arr [lfu_pkg::NumCells];
  lfu_pkg::rank_t               rank_arr [lfu_pkg::NumCells];
  lfu_pkg::cand_t               cand_in  [lfu_pkg::NumCells];
  lfu_pkg::cand_t               cand_out [lfu_pkg::NumCells];
  lfu_pkg::cand_t               victim;

  lfu_pkg::cell_cmd_t           cmd;
  logic                         req_accept, slot_free, commit, settled, hit;
  lfu_pkg::data_t               hit_data;
  lfu_pkg::rank_t               hit_rank;
  lfu_pkg::key_t                victim_key;
  logic [lfu_pkg::CntW-1:0]     n_valid, cap_eff;
  logic [lfu_pkg::NumCells-1:0] free_sel;
  logic                         free_found;

  assign req_accept = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == StIdle);
  assign slot_free  = !rsp_valid_q || rsp_o.ready;
  assign settled    = (settle_q == lfu_pkg::SettleW'(lfu_pkg::NumCells));
  assign victim     = cand_out[lfu_pkg::NumCells-1];

  // Row of cells; candidate passes from each cell to the next
  for (genvar g = 0; g < lfu_pkg::NumCells; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign cand_in[g] = '0;
    end else begin : g_link
      assign cand_in[g] = cand_out[g-1];
    end
    lfu_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (lfu_pkg::IdxW'(g)),
      .cmd_i      (cmd),
      .sel_i      (sel_vec[g]),
      .evict_i    (evict_vec[g]),
      .req_key_i  (req_key_q),
      .cand_i     (cand_in[g]),
      .valid_o    (valid_vec[g]),
      .match_o    (match_vec[g]),
      .key_o      (key_arr[g]),
      .data_o     (data_arr[g]),
      .rank_o     (rank_arr[g]),
      .cand_o     (cand_out[g])
    );
  end

  // Gather hit word, fill level, victim slot and first free slot
  always_comb begin
    hit_data   = '0;
    hit_rank   = '0;
    victim_key = '0;
    n_valid    = '0;
    evict_vec  = '0;
    for (int i = 0; i < lfu_pkg::NumCells; i++) begin
      if (match_vec[i]) begin
        hit_data = hit_data | data_arr[i];
        hit_rank = hit_rank | rank_arr[i];
      end
      n_valid = n_valid + lfu_pkg::CntW'(valid_vec[i]);
      if ((state_q == StWalk) && victim.found && (victim.idx == lfu_pkg::IdxW'(i))) begin
        evict_vec[i] = 1'b1;
        victim_key   = key_arr[i];
      end
    end
    hit = |match_vec;
    if (lfu_pkg::CntW'(cap_q) > lfu_pkg::CntW'(lfu_pkg::NumCells)) begin
      cap_eff = lfu_pkg::CntW'(lfu_pkg::NumCells);
    end else begin
      cap_eff = lfu_pkg::CntW'(cap_q);
    end
  end

  assign avail_vec = ~valid_vec | evict_vec;

  always_comb begin
    free_sel   = '0;
    free_found = 1'b0;
    for (int i = 0; i < lfu_pkg::NumCells; i++) begin
      if (avail_vec[i] && !free_found) begin
        free_sel[i] = 1'b1;
        free_found  = 1'b1;
      end
    end
  end

  // Sequencer: decide the update and the result word
  always_comb begin
    state_d       = state_q;
    commit        = 1'b0;
    sel_vec       = '0;
    cmd           = '0;
    cmd.op        = lfu_pkg::CmdNone;
    cmd.key       = req_key_q;
    cmd.data      = req_data_q;
    rsp_hit_d     = 1'b0;
    rsp_value_d   = '0;
    rsp_evicted_d = 1'b0;
    rsp_evkey_d   = '0;
    unique case (state_q)
      StIdle: begin
        if (req_accept) begin
          state_d = StMatch;
        end
      end
      StMatch: begin
        if (req_op_q == lfu_pkg::OpGet) begin
          rsp_hit_d   = hit;
          rsp_value_d = hit ? hit_data : '0;
          commit      = slot_free;
          if (commit && hit) begin
            cmd.op       = lfu_pkg::CmdTouch;
            cmd.rank_ref = hit_rank;
            sel_vec      = match_vec;
          end
        end else if (cap_eff == '0) begin
          commit = slot_free;
        end else if (hit) begin
          rsp_hit_d = 1'b1;
          commit    = slot_free;
          if (commit) begin
            cmd.op       = lfu_pkg::CmdTouch;
            cmd.wr_data  = 1'b1;
            cmd.rank_ref = hit_rank;
            sel_vec      = match_vec;
          end
        end else if (n_valid < cap_eff) begin
          commit = slot_free;
          if (commit) begin
            cmd.op  = lfu_pkg::CmdInsert;
            sel_vec = free_sel;
          end
        end else begin
          state_d = StWalk;
        end
        if (commit) begin
          state_d = StIdle;
        end
      end
      StWalk: begin
        rsp_evicted_d = 1'b1;
        rsp_evkey_d   = victim_key;
        commit        = settled && slot_free;
        if (commit) begin
          cmd.op       = lfu_pkg::CmdInsert;
          cmd.do_evict = 1'b1;
          cmd.rank_ref = victim.rank;
          sel_vec      = free_sel;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Restart the settle count on every table update
  always_comb begin
    if (cmd.op != lfu_pkg::CmdNone) begin
      settle_d = '0;
    end else if (!settled) begin
      settle_d = settle_q + 1'b1;
    end else begin
      settle_d = settle_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cap_q       <= lfu_pkg::CapReset;
      settle_q    <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      settle_q <= settle_d;
      if (cfg_we_i) begin
        cap_q <= cfg_data_i;
      end
      if (commit) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // Hold the request word and the result word
  always_ff @(posedge clk_i) begin
    if (req_accept) begin
      req_op_q   <= req_i.operation;
      req_key_q  <= req_i.key;
      req_data_q <= req_i.value;
    end
    if (commit) begin
      rsp_hit_q     <= rsp_hit_d;
      rsp_value_q   <= rsp_value_d;
      rsp_evicted_q <= rsp_evicted_d;
      rsp_evkey_q   <= rsp_evkey_d;
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.hit         = rsp_hit_q;
  assign rsp_o.read_value  = rsp_value_q;
  assign rsp_o.evicted     = rsp_evicted_q;
  assign rsp_o.evicted_key = rsp_evkey_q;

`ifndef NO_ASSERTIONS
  // keys stay unique among valid entries
  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot0(match_vec))
    else $error("more than one cell matches the request key");

  // an eviction always has a settled victim
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (state_q == StWalk && commit) |-> (victim.found && settled))
    else $error("eviction committed without a victim");

  // an insert targets exactly one free slot, which is valid afterwards
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (cmd.op == lfu_pkg::CmdInsert) |->
                   ($onehot(sel_vec) && ((sel_vec & avail_vec) == sel_vec)))
    else $error("insert without a single free slot");

  // a result word is only written outside idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   commit |-> (state_q != StIdle))
    else $error("result committed while idle");
`endif

endmodule
